// ===== hw/rtl/srq_pkg.sv =====
package srq_pkg;

    // Default sizes, handed to the top-level parameters
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_WIDTH_DEF    = 8;
    localparam int TIME_WIDTH_DEF  = 16;

    // Fixed width of the occupancy field
    localparam int OCC_W = 5;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_POP    = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_PEEK   = 2'd3
    } srq_func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } srq_status_t;

    // Per-cycle command from the queue control to every cell
    typedef struct packed {
        logic ins;       // insert in progress (queue not full)
        logic shift_up;  // take the entry of the next cell toward the tail
    } srq_cell_ctrl_t;

    // What a cell shows its neighbors and the queue control
    typedef struct packed {
        logic valid;     // cell holds an entry
        logic key_lt;    // valid and stored key < new key
        logic id_eq;     // valid and stored id == requested id
    } srq_cell_stat_t;

endpackage

// ===== hw/rtl/srq_req_if.sv =====
interface srq_req_if #(
    parameter int ID_WIDTH   = srq_pkg::ID_WIDTH_DEF,
    parameter int TIME_WIDTH = srq_pkg::TIME_WIDTH_DEF
);
    import srq_pkg::*;

    logic                  valid;
    logic                  ready;
    srq_func_t             func;
    logic [ID_WIDTH-1:0]   in_id;
    logic [TIME_WIDTH-1:0] in_time;

    modport source (output valid, func, in_id, in_time, input ready);
    modport sink   (input valid, func, in_id, in_time, output ready);
    modport mon    (input valid, ready, func, in_id, in_time);
endinterface

// ===== hw/rtl/srq_rsp_if.sv =====
interface srq_rsp_if #(
    parameter int ID_WIDTH   = srq_pkg::ID_WIDTH_DEF,
    parameter int TIME_WIDTH = srq_pkg::TIME_WIDTH_DEF
);
    import srq_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [ID_WIDTH-1:0]   out_id;
    logic [TIME_WIDTH-1:0] out_time;
    srq_status_t           status;
    logic [OCC_W-1:0]      occupancy;

    modport source (output valid, out_id, out_time, status, occupancy, input ready);
    modport sink   (input valid, out_id, out_time, status, occupancy, output ready);
    modport mon    (input valid, ready, out_id, out_time, status, occupancy);
endinterface

// ===== hw/rtl/srq_cell.sv =====
module srq_cell #(
    parameter int ID_WIDTH   = srq_pkg::ID_WIDTH_DEF,
    parameter int TIME_WIDTH = srq_pkg::TIME_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  srq_pkg::srq_cell_ctrl_t ctrl,
    input  logic [ID_WIDTH-1:0]    new_id,
    input  logic [TIME_WIDTH-1:0]  new_key,
    // neighbor toward the head
    input  srq_pkg::srq_cell_stat_t left_stat,
    input  logic [ID_WIDTH-1:0]    left_id,
    input  logic [TIME_WIDTH-1:0]  left_key,
    // neighbor toward the tail
    input  srq_pkg::srq_cell_stat_t right_stat,
    input  logic [ID_WIDTH-1:0]    right_id,
    input  logic [TIME_WIDTH-1:0]  right_key,
    output srq_pkg::srq_cell_stat_t stat,
    output logic [ID_WIDTH-1:0]    id,
    output logic [TIME_WIDTH-1:0]  key
);
    import srq_pkg::*;

    logic                  valid_reg, valid_next;
    logic [ID_WIDTH-1:0]   id_reg, id_next;
    logic [TIME_WIDTH-1:0] key_reg, key_next;

    assign stat.valid  = valid_reg;
    assign stat.key_lt = valid_reg && (key_reg < new_key);
    assign stat.id_eq  = valid_reg && (id_reg == new_id);
    assign id  = id_reg;
    assign key = key_reg;

    // Insert: cells with smaller keys hold, the first other cell takes the
    // new entry, the rest take their head-side neighbor.
    // Removal: cells at and past the removed slot take their tail-side neighbor.
    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        key_next   = key_reg;
        if (ctrl.ins && !stat.key_lt)
        begin
            if (left_stat.key_lt)
            begin
                valid_next = 1'b1;
                id_next    = new_id;
                key_next   = new_key;
            end
            else
            begin
                valid_next = left_stat.valid;
                id_next    = left_id;
                key_next   = left_key;
            end
        end
        else if (ctrl.shift_up)
        begin
            valid_next = right_stat.valid;
            id_next    = right_id;
            key_next   = right_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        key_reg <= key_next;
    end

endmodule

// ===== hw/rtl/sorted_ready_queue.sv =====
// sorted_ready_queue: ascending-key ready queue built as a row of cells.
// Result: registered; it appears on rsp in the cycle after the request transfer.
// Throughput: one operation per cycle; every cell compares and shifts in the
// same cycle, so the next request is taken as soon as the result register frees.
// Reset: cell valid bits, the entry count and the result valid clear at once;
// key and id storage is not cleared and no clearing pass is needed.
module sorted_ready_queue #(
    parameter int QUEUE_DEPTH = srq_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_WIDTH    = srq_pkg::ID_WIDTH_DEF,
    parameter int TIME_WIDTH  = srq_pkg::TIME_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    srq_req_if.sink   req,
    srq_rsp_if.source rsp
);
    import srq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Cell row: index 0 is the head
    srq_cell_ctrl_t        ctrl;
    srq_cell_stat_t        stat [QUEUE_DEPTH];
    logic [ID_WIDTH-1:0]   ids  [QUEUE_DEPTH];
    logic [TIME_WIDTH-1:0] keys [QUEUE_DEPTH];

    logic [QUEUE_DEPTH-1:0] match;     // candidate slot for pop/peek/remove
    logic [QUEUE_DEPTH-1:0] found_le;  // a candidate at this slot or nearer the head
    logic [QUEUE_DEPTH-1:0] first;     // one-hot: the slot actually taken

    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  out_valid_reg;
    logic [ID_WIDTH-1:0]   out_id_reg, out_id_next;
    logic [TIME_WIDTH-1:0] out_time_reg, out_time_next;
    srq_status_t           status_reg, status_next;
    logic [OCC_W-1:0]      occ_reg;

    logic accept;
    logic full, empty, found_any;
    logic is_ins, is_del, is_rem;
    logic [ID_WIDTH-1:0]   sel_id;
    logic [TIME_WIDTH-1:0] sel_key;

    // Result register parts the two sides: a request is taken whenever the
    // pending result is gone or leaves in this cycle.
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign full   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign is_ins = (req.func == FUNC_INSERT);
    assign is_rem = (req.func == FUNC_REMOVE);
    assign is_del = (req.func == FUNC_POP) || is_rem;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            srq_cell_stat_t        l_stat, r_stat;
            logic [ID_WIDTH-1:0]   l_id, r_id;
            logic [TIME_WIDTH-1:0] l_key, r_key;

            if (g == 0)
            begin : g_head
                // head sees a virtual smaller key: insert lands here if cell 0 is not smaller
                assign l_stat = '{valid: 1'b1, key_lt: 1'b1, id_eq: 1'b0};
                assign l_id   = '0;
                assign l_key  = '0;
                assign match[g]    = is_rem ? stat[g].id_eq : stat[g].valid;
                assign found_le[g] = match[g];
                assign first[g]    = match[g];
            end
            else
            begin : g_body
                assign l_stat = stat[g-1];
                assign l_id   = ids[g-1];
                assign l_key  = keys[g-1];
                // pop and peek only ever take the head
                assign match[g]    = is_rem && stat[g].id_eq;
                assign found_le[g] = |match[g:0];
                assign first[g]    = match[g] && !found_le[g-1];
            end

            if (g == QUEUE_DEPTH - 1)
            begin : g_tail
                assign r_stat = '{valid: 1'b0, key_lt: 1'b0, id_eq: 1'b0};
                assign r_id   = '0;
                assign r_key  = '0;
            end
            else
            begin : g_mid
                assign r_stat = stat[g+1];
                assign r_id   = ids[g+1];
                assign r_key  = keys[g+1];
            end

            srq_cell_ctrl_t cell_ctrl;
            assign cell_ctrl.ins      = ctrl.ins;
            assign cell_ctrl.shift_up = ctrl.shift_up && found_le[g];

            srq_cell #(
                .ID_WIDTH   (ID_WIDTH),
                .TIME_WIDTH (TIME_WIDTH)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (cell_ctrl),
                .new_id     (req.in_id),
                .new_key    (req.in_time),
                .left_stat  (l_stat),
                .left_id    (l_id),
                .left_key   (l_key),
                .right_stat (r_stat),
                .right_id   (r_id),
                .right_key  (r_key),
                .stat       (stat[g]),
                .id         (ids[g]),
                .key        (keys[g])
            );
        end
    endgenerate

    assign found_any = found_le[QUEUE_DEPTH-1];

    // Row-wide command: only on a transfer, and only if the op changes the queue
    assign ctrl.ins      = accept && is_ins && !full;
    assign ctrl.shift_up = accept && is_del && found_any;

    // One-hot select of the taken entry
    always_comb
    begin
        sel_id  = '0;
        sel_key = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            sel_id  = sel_id  | (ids[i]  & {ID_WIDTH{first[i]}});
            sel_key = sel_key | (keys[i] & {TIME_WIDTH{first[i]}});
        end
    end

    // Result and count for the op in flight
    always_comb
    begin
        out_id_next   = '0;
        out_time_next = '0;
        status_next   = ST_OK;
        count_next    = count_reg;
        if (is_ins)
        begin
            if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else if (empty)
        begin
            status_next = ST_EMPTY;
        end
        else if (!found_any)
        begin
            status_next = ST_NOT_FOUND;
        end
        else
        begin
            out_id_next   = sel_id;
            out_time_next = sel_key;
            if (is_del)
            begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_id_reg   <= out_id_next;
            out_time_reg <= out_time_next;
            status_reg   <= status_next;
            occ_reg      <= OCC_W'(count_next);
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.out_id    = out_id_reg;
    assign rsp.out_time  = out_time_reg;
    assign rsp.status    = status_reg;
    assign rsp.occupancy = occ_reg;

endmodule

// ===== hw/rtl/srq_checker.sv =====
module srq_checker #(
    parameter int QUEUE_DEPTH = srq_pkg::QUEUE_DEPTH_DEF
) (
    input logic       clk,
    input logic       rst_n,
    srq_req_if.sink   req,
    srq_rsp_if.source rsp
);
    import srq_pkg::*;

    // Stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.out_id)
            && $stable(rsp.out_time) && $stable(rsp.status) && $stable(rsp.occupancy))
        else $error("result changed while stalled");

    // Dropped insert only when the queue is at capacity
    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == ST_FULL |-> rsp.occupancy == OCC_W'(QUEUE_DEPTH))
        else $error("full status with queue not at capacity");

    // Empty status leaves nothing behind
    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == ST_EMPTY |-> rsp.occupancy == '0)
        else $error("empty status with entries held");

    // Failed ops return a zero entry
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ST_OK |-> rsp.out_id == '0 && rsp.out_time == '0)
        else $error("nonzero entry on failed op");

    // A request transfer yields a result in the next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> rsp.valid)
        else $error("result missing after request transfer");

endmodule

bind sorted_ready_queue srq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_srq_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
);
